### rtl/core/pfde_pkg.sv
// Shared types and constants for the packed framebuffer draw engine.
package pfde_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 160;
  localparam int ROW_WORDS     = (SCREEN_WIDTH + 1) / 2;
  localparam int STORE_WORDS   = ROW_WORDS * SCREEN_HEIGHT;

  // Signed working width for coordinate math: holds x + w + 1 and y + h.
  localparam int COORD_BITS = 12;
  localparam int COL_BITS   = $clog2(ROW_WORDS + 1);
  localparam int ROW_BITS   = $clog2(SCREEN_HEIGHT + 1);
  localparam int ADDR_BITS  = $clog2(STORE_WORDS + 1);
  localparam int RAM_AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  localparam logic [15:0] LOW_LANE_MASK  = 16'h00FF;
  localparam logic [15:0] HIGH_LANE_MASK = 16'hFF00;

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

### rtl/core/pfde_if.sv
// Command and response channel interfaces for the draw engine.
interface pfde_cmd_if import pfde_pkg::*;;
  logic               valid;
  logic               ready;
  mode_e              mode;
  logic signed [9:0]  pos_x;
  logic signed [9:0]  pos_y;
  logic        [8:0]  span_w;
  logic        [8:0]  span_h;
  logic        [7:0]  color;

  modport source (output valid, mode, pos_x, pos_y, span_w, span_h, color, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, span_w, span_h, color, output ready);
endinterface

interface pfde_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_word;

  modport source (output valid, read_word, input ready);
  modport sink   (input valid, read_word, output ready);
endinterface

### rtl/core/pfde_ram.sv
// Generic single-port RAM with registered read data.
module pfde_ram #(
  parameter int Width = 16,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### rtl/core/packed_framebuffer_draw_engine.sv
// Top level of the packed framebuffer draw engine: command sequencer and frame store.
//
// Usage: commands arrive on cmd_i (valid/ready), one item per command, and every
// command returns exactly one item on rsp_o. Fill rectangle, vertical line and
// clear screen answer zero; read word answers the packed word at row pos_y, word
// column pos_x/2 (zero when off screen).
// The frame store is one single-port RAM of ROW_WORDS x SCREEN_HEIGHT words, and
// one address adder (row base plus word column) serves every access, so the
// block works on one command at a time and cmd_i.ready is high only when idle.
// Steps per command after accept: clip, row base, the walk below, then the result:
//   fill rectangle: one write per clipped word of each clipped row
//   clear screen:   every word, ROW_WORDS x SCREEN_HEIGHT (19200 at 240x160)
//   vertical line:  one read and one write per clipped row
//   read word:      one read, whose data is then registered as the result
//   empty or off-screen spans: no walk, straight to the result
// In fill and clear, the single RAM port sets the rate: one word written per cycle.
// A finished result sits in an output register; the next command is taken while
// it waits. If the receiver still stalls when a second result is ready, the
// sequencer holds that result until the output register frees up.
// Reset clears the sequencer and the response valid; the frame store content
// is undefined until written (no clearing pass).
module packed_framebuffer_draw_engine import pfde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfde_cmd_if.sink   cmd_i,
  pfde_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_BASE,
    S_FILL,
    S_LINE_RD,
    S_LINE_WR,
    S_READ_RD,
    S_READ_WAIT,
    S_DONE
  } state_e;

  state_e state_q;

  // Captured command.
  mode_e             mode_q;
  logic signed [9:0] pos_x_q;
  logic signed [9:0] pos_y_q;
  logic        [8:0] span_w_q;
  logic        [8:0] span_h_q;
  logic        [7:0] color_q;

  // Clipped walk bounds and walk counters.
  logic [COL_BITS-1:0]  col_first_q, col_last_q, col_q;
  logic [ROW_BITS-1:0]  row_q, row_last_q;
  logic                 empty_q;
  logic                 lane_q;
  logic [ADDR_BITS-1:0] base_q;

  logic [15:0] res_q;
  logic        rsp_valid_q;
  logic [15:0] rsp_word_q;

  // Clip logic, evaluated in S_CLIP from the captured command.
  coord_t xs, ys, wv, hv;
  coord_t x_lo, x_hi, x_lo_c, x_hi_c, y_lo_c, y_hi_c, y_end;
  logic   x_off, y_off, rows_empty;
  logic [COL_BITS-1:0] clip_c0, clip_c1;
  logic [ROW_BITS-1:0] clip_r0, clip_rl;
  logic                clip_empty;

  always_comb begin
    xs = coord_t'(pos_x_q);
    ys = coord_t'(pos_y_q);
    wv = coord_t'({1'b0, span_w_q});
    hv = coord_t'({1'b0, span_h_q});

    // Round the horizontal span out to whole words, then clip.
    x_lo   = xs & ~coord_t'(1);
    x_hi   = (xs + wv + coord_t'(1)) & ~coord_t'(1);
    x_lo_c = (x_lo < coord_t'(0)) ? coord_t'(0) : x_lo;
    x_hi_c = (x_hi > coord_t'(SCREEN_WIDTH)) ? coord_t'(SCREEN_WIDTH) : x_hi;

    y_end      = ys + hv;
    y_lo_c     = (ys < coord_t'(0)) ? coord_t'(0) : ys;
    y_hi_c     = (y_end > coord_t'(SCREEN_HEIGHT)) ? coord_t'(SCREEN_HEIGHT) : y_end;
    rows_empty = (y_hi_c <= y_lo_c);

    x_off = (xs < coord_t'(0)) || (xs >= coord_t'(SCREEN_WIDTH));
    y_off = (ys < coord_t'(0)) || (ys >= coord_t'(SCREEN_HEIGHT));

    clip_c0    = '0;
    clip_c1    = '0;
    clip_r0    = '0;
    clip_rl    = '0;
    clip_empty = 1'b0;

    unique case (mode_q)
      MODE_FILL: begin
        clip_c0    = COL_BITS'(x_lo_c >>> 1);
        clip_c1    = COL_BITS'(((x_hi_c + coord_t'(1)) >>> 1) - coord_t'(1));
        clip_r0    = ROW_BITS'(y_lo_c);
        clip_rl    = ROW_BITS'(y_hi_c - coord_t'(1));
        clip_empty = (x_hi_c <= x_lo_c) || rows_empty;
      end
      MODE_LINE: begin
        clip_c0    = COL_BITS'(xs >>> 1);
        clip_c1    = COL_BITS'(xs >>> 1);
        clip_r0    = ROW_BITS'(y_lo_c);
        clip_rl    = ROW_BITS'(y_hi_c - coord_t'(1));
        clip_empty = x_off || rows_empty;
      end
      MODE_CLEAR: begin
        clip_c0    = '0;
        clip_c1    = COL_BITS'(ROW_WORDS - 1);
        clip_r0    = '0;
        clip_rl    = ROW_BITS'(SCREEN_HEIGHT - 1);
        clip_empty = 1'b0;
      end
      MODE_READ: begin
        clip_c0    = COL_BITS'(xs >>> 1);
        clip_c1    = COL_BITS'(xs >>> 1);
        clip_r0    = ROW_BITS'(ys);
        clip_rl    = ROW_BITS'(ys);
        clip_empty = x_off || y_off;
      end
      default: begin
        clip_empty = 1'b1;
      end
    endcase
  end

  // Shared address adder and RAM port.
  logic [ADDR_BITS-1:0] addr;
  logic                 ram_we;
  logic [15:0]          ram_wdata, ram_rdata, merged;

  assign addr = base_q + ADDR_BITS'(col_q);

  // Replace the byte lane of the line's pixel, keep the other.
  assign merged = lane_q ? ((ram_rdata & LOW_LANE_MASK) | {color_q, 8'h00})
                         : ((ram_rdata & HIGH_LANE_MASK) | {8'h00, color_q});

  assign ram_we    = (state_q == S_FILL) || (state_q == S_LINE_WR);
  assign ram_wdata = (state_q == S_FILL) ? {color_q, color_q} : merged;

  pfde_ram #(
    .Width (16),
    .Depth (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr[RAM_AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic last_col, last_row;
  assign last_col = (col_q == col_last_q);
  assign last_row = (row_q == row_last_q);

  assign cmd_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_word = rsp_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      rsp_word_q  <= '0;
      mode_q      <= MODE_FILL;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      span_w_q    <= '0;
      span_h_q    <= '0;
      color_q     <= '0;
      col_first_q <= '0;
      col_last_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      row_last_q  <= '0;
      empty_q     <= 1'b0;
      lane_q      <= 1'b0;
      base_q      <= '0;
      res_q       <= '0;
    end else begin
      // Drop the response once taken, unless S_DONE reloads it below.
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            mode_q   <= cmd_i.mode;
            pos_x_q  <= cmd_i.pos_x;
            pos_y_q  <= cmd_i.pos_y;
            span_w_q <= cmd_i.span_w;
            span_h_q <= cmd_i.span_h;
            color_q  <= cmd_i.color;
            res_q    <= '0;
            state_q  <= S_CLIP;
          end
        end
        S_CLIP: begin
          col_first_q <= clip_c0;
          col_q       <= clip_c0;
          col_last_q  <= clip_c1;
          row_q       <= clip_r0;
          row_last_q  <= clip_rl;
          empty_q     <= clip_empty;
          lane_q      <= pos_x_q[0];
          state_q     <= S_BASE;
        end
        S_BASE: begin
          // Start address of the first row.
          base_q <= ADDR_BITS'(row_q * ROW_WORDS);
          if (empty_q) begin
            state_q <= S_DONE;
          end else begin
            unique case (mode_q)
              MODE_FILL, MODE_CLEAR: state_q <= S_FILL;
              MODE_LINE:             state_q <= S_LINE_RD;
              MODE_READ:             state_q <= S_READ_RD;
              default:               state_q <= S_DONE;
            endcase
          end
        end
        S_FILL: begin
          // One word per cycle, row by row.
          if (last_col) begin
            col_q <= col_first_q;
            if (last_row) begin
              state_q <= S_DONE;
            end else begin
              row_q  <= row_q + ROW_BITS'(1);
              base_q <= base_q + ADDR_BITS'(ROW_WORDS);
            end
          end else begin
            col_q <= col_q + COL_BITS'(1);
          end
        end
        S_LINE_RD: begin
          state_q <= S_LINE_WR;
        end
        S_LINE_WR: begin
          if (last_row) begin
            state_q <= S_DONE;
          end else begin
            row_q   <= row_q + ROW_BITS'(1);
            base_q  <= base_q + ADDR_BITS'(ROW_WORDS);
            state_q <= S_LINE_RD;
          end
        end
        S_READ_RD: begin
          state_q <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          res_q   <= ram_rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_word_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
